>>> sv/tlh_pkg.sv
// Shared constants and types for the text line hash block.
`default_nettype none

package tlh_pkg;

    localparam int SUM_W   = 32;
    localparam int HALF_W  = 16;
    localparam int SHIFT_W = 4;
    localparam int CHAR_W  = 8;
    localparam int HASH_W  = 17;

    localparam logic [SHIFT_W-1:0] SHIFT_STEP   = 4'd7;
    localparam logic [CHAR_W-1:0]  CHAR_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0]  CHAR_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0]  CHAR_SPACE   = 8'd32;
    localparam logic [SUM_W-1:0]   SUM_INIT     = 32'd1;

    // One result leaving the hash core.
    typedef struct packed {
        logic              valid;
        logic [HASH_W-1:0] hash;
        logic              is_end;
    } t_tlh_res;

endpackage

`default_nettype wire

>>> sv/text_line_hash.sv
// Top level of the text line hash: input register, hash core, result register.
`default_nettype none

// Hashes a byte stream line by line. One byte is accepted every cycle while
// ready is high; a result (the folded 17-bit hash of a line, or an end
// marker) follows the newline or end beat that causes it: the beat sits in
// the input register, the result in the result register. The whole per-byte
// update (barrel shift of the byte, 32-bit add, two 16-bit folds) sits
// between those two registers. Ready drops only while a byte sits in the
// input register and a result waits at the output with m_axis_tready low.
module text_line_hash
    import tlh_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wen,
    input  wire logic        i_cfg_wdata,    // ignore_blanks
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  wire logic        s_axis_tlast,   // end_of_input
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [16:0] hash_value, [23:17] zero
    output logic             m_axis_tlast    // is_end
);

    logic              r_ignore_blanks;
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_last;
    logic              r_out_valid;
    logic [HASH_W-1:0] r_out_hash;
    logic              r_out_end;

    logic     advance;
    t_tlh_res res;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;

    tlh_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (r_in_valid && advance),
        .i_char          (r_in_char),
        .i_eoi           (r_in_last),
        .i_ignore_blanks (r_ignore_blanks),
        .o_res           (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ignore_blanks <= 1'b0;
        end else if (i_cfg_wen) begin
            r_ignore_blanks <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_char <= s_axis_tdata[CHAR_W-1:0];
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res.valid) begin
            r_out_hash <= res.hash;
            r_out_end  <= res.is_end;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(24-HASH_W){1'b0}}, r_out_hash};
    assign m_axis_tlast  = r_out_end;

`ifndef NO_ASSERTIONS
    // An end beat that leaves the input register shows up as a zero end marker.
    a_end_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_in_last && advance |=>
            m_axis_tvalid && m_axis_tlast && (m_axis_tdata == 24'd0))
        else $error("end beat did not produce end marker");

    // The double fold never exceeds 0x10000.
    a_hash_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata <= 24'h010000))
        else $error("folded hash out of range");

    // A result only goes away after it was taken.
    a_out_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // A byte in the input register is never overwritten while held.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_char) && $stable(r_in_last))
        else $error("held input beat lost");
`endif

endmodule

`default_nettype wire

>>> sv/tlh_core.sv
// Per-line hash state and the combinational update for one byte.
`default_nettype none

module tlh_core
    import tlh_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [CHAR_W-1:0] i_char,
    input  wire logic              i_eoi,
    input  wire logic              i_ignore_blanks,
    output t_tlh_res               o_res
);

    logic [SUM_W-1:0]   r_sum;
    logic [SHIFT_W-1:0] r_shift;
    logic               r_pending;

    logic [SUM_W-1:0]   n_sum;
    logic [SHIFT_W-1:0] n_shift;
    logic               n_pending;

    logic               blank;
    logic [SHIFT_W-1:0] shift_eff;
    logic [SUM_W-1:0]   addend;
    logic [HALF_W:0]    fold1;
    logic [HALF_W:0]    fold2;

    assign blank     = (i_char == CHAR_SPACE) || (i_char == CHAR_TAB);
    // A blank run in ignore mode costs one extra shift step before the next byte.
    assign shift_eff = (r_pending && i_ignore_blanks) ? r_shift + SHIFT_STEP : r_shift;
    assign addend    = {{(SUM_W-CHAR_W){1'b0}}, i_char} << shift_eff;

    assign fold1 = {1'b0, r_sum[HALF_W-1:0]} + {1'b0, r_sum[SUM_W-1:HALF_W]};
    assign fold2 = {1'b0, fold1[HALF_W-1:0]} + {{HALF_W{1'b0}}, fold1[HALF_W]};

    always_comb begin
        n_sum         = r_sum;
        n_shift       = r_shift;
        n_pending     = r_pending;
        o_res.valid   = 1'b0;
        o_res.hash    = '0;
        o_res.is_end  = 1'b0;
        if (i_step) begin
            if (i_eoi) begin
                n_sum        = SUM_INIT;
                n_shift      = '0;
                n_pending    = 1'b0;
                o_res.valid  = 1'b1;
                o_res.is_end = 1'b1;
            end else if (i_char == CHAR_NEWLINE) begin
                n_sum       = SUM_INIT;
                n_shift     = '0;
                n_pending   = 1'b0;
                o_res.valid = 1'b1;
                o_res.hash  = fold2;
            end else if (i_ignore_blanks && blank) begin
                n_pending = 1'b1;
            end else begin
                n_sum     = r_sum + addend;
                n_shift   = shift_eff + SHIFT_STEP;
                n_pending = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= SUM_INIT;
            r_shift   <= '0;
            r_pending <= 1'b0;
        end else begin
            r_sum     <= n_sum;
            r_shift   <= n_shift;
            r_pending <= n_pending;
        end
    end

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for text_line_hash: directed table, long line, random phases.
`timescale 1ns / 100ps

module testbench
    import tlh_pkg::*;
();

    typedef enum logic {ROW_BEAT, ROW_MODE} t_row_kind;

    // One row of the directed table. A ROW_MODE row rewrites ignore_blanks.
    typedef struct packed {
        t_row_kind   kind;
        logic        mode;
        logic [7:0]  chr;
        logic        eoi;
        logic        lit;       // 1: expected result typed in below
        logic [16:0] lit_hash;
        logic        lit_end;
    } t_line_row;

    typedef struct packed {
        logic [16:0] hash;
        logic        is_end;
    } t_hash_rec;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wen = 1'b0;
    logic        i_cfg_wdata = 1'b0;    // ignore_blanks
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] char_code
    logic        s_axis_tlast = 1'b0;   // end_of_input
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // [16:0] hash_value, [23:17] zero
    logic        m_axis_tlast;          // is_end

    text_line_hash dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Predictor state
    logic [31:0] line_sum = SUM_INIT;
    logic [3:0]  line_shift = '0;
    logic        blank_seen = 1'b0;
    logic        blank_mode = 1'b0;

    t_hash_rec   line_hash_q[$];
    int          err_count = 0;
    int          gap_max = 6;

    t_line_row directed_rows [0:26] = '{
        '{ROW_BEAT, 1'b0, CHAR_NEWLINE, 1'b0, 1'b1, 17'd1, 1'b0},  // empty line after reset
        '{ROW_BEAT, 1'b0, 8'h00,        1'b0, 1'b0, 17'd0, 1'b0},
        '{ROW_BEAT, 1'b0, CHAR_NEWLINE, 1'b0, 1'b1, 17'd1, 1'b0},  // zero byte adds nothing
        '{ROW_BEAT, 1'b0, 8'hFF,        1'b0, 1'b0, 17'd0, 1'b0},
        '{ROW_BEAT, 1'b0, 8'hFF,        1'b0, 1'b0, 17'd0, 1'b0},
        '{ROW_BEAT, 1'b0, CHAR_SPACE,   1'b0, 1'b0, 17'd0, 1'b0},
        '{ROW_BEAT, 1'b0, CHAR_TAB,     1'b0, 1'b0, 17'd0, 1'b0},
        '{ROW_BEAT, 1'b0, 8'h41,        1'b0, 1'b0, 17'd0, 1'b0},
        '{ROW_BEAT, 1'b0, CHAR_NEWLINE, 1'b0, 1'b0, 17'd0, 1'b0},
        '{ROW_BEAT, 1'b0, 8'h78,        1'b0, 1'b0, 17'd0, 1'b0},
        '{ROW_BEAT, 1'b0, CHAR_NEWLINE, 1'b1, 1'b1, 17'd0, 1'b1},  // end drops partial line
        '{ROW_BEAT, 1'b0, 8'hFF,        1'b1, 1'b1, 17'd0, 1'b1},
        '{ROW_MODE, 1'b1, 8'h00,        1'b0, 1'b0, 17'd0, 1'b0},
        '{ROW_BEAT, 1'b0, CHAR_SPACE,   1'b0, 1'b0, 17'd0, 1'b0},
        '{ROW_BEAT, 1'b0, CHAR_TAB,     1'b0, 1'b0, 17'd0, 1'b0},
        '{ROW_BEAT, 1'b0, 8'h61,        1'b0, 1'b0, 17'd0, 1'b0},
        '{ROW_BEAT, 1'b0, CHAR_SPACE,   1'b0, 1'b0, 17'd0, 1'b0},
        '{ROW_BEAT, 1'b0, 8'h62,        1'b0, 1'b0, 17'd0, 1'b0},
        '{ROW_BEAT, 1'b0, CHAR_TAB,     1'b0, 1'b0, 17'd0, 1'b0},
        '{ROW_BEAT, 1'b0, CHAR_NEWLINE, 1'b0, 1'b0, 17'd0, 1'b0},  // trailing blank ignored
        '{ROW_BEAT, 1'b0, CHAR_SPACE,   1'b0, 1'b0, 17'd0, 1'b0},
        '{ROW_BEAT, 1'b0, CHAR_NEWLINE, 1'b0, 1'b1, 17'd1, 1'b0},  // blank-only line
        '{ROW_BEAT, 1'b0, 8'h63,        1'b0, 1'b0, 17'd0, 1'b0},
        '{ROW_BEAT, 1'b0, CHAR_SPACE,   1'b0, 1'b0, 17'd0, 1'b0},
        '{ROW_MODE, 1'b0, 8'h00,        1'b0, 1'b0, 17'd0, 1'b0},  // switch with blank pending
        '{ROW_BEAT, 1'b0, 8'h64,        1'b0, 1'b0, 17'd0, 1'b0},
        '{ROW_BEAT, 1'b0, CHAR_NEWLINE, 1'b0, 1'b0, 17'd0, 1'b0}
    };

    function automatic void line_restart();
        line_sum   = SUM_INIT;
        line_shift = '0;
        blank_seen = 1'b0;
    endfunction

    // Advances the line hash by one beat; returns 1 when the beat yields a result.
    function automatic bit hash_step(input logic [7:0] chr, input logic eoi,
                                     output logic [16:0] hash, output logic is_end);
        logic [16:0] fold1;
        hash   = '0;
        is_end = 1'b0;
        if (eoi) begin
            line_restart();
            is_end = 1'b1;
            return 1'b1;
        end
        if (chr == CHAR_NEWLINE) begin
            fold1 = {1'b0, line_sum[15:0]} + {1'b0, line_sum[31:16]};
            hash  = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
            line_restart();
            return 1'b1;
        end
        if (blank_mode && (chr == CHAR_SPACE || chr == CHAR_TAB)) begin
            blank_seen = 1'b1;
            return 1'b0;
        end
        // a blank run counts as one extra shift step
        if (blank_mode && blank_seen)
            line_shift = line_shift + SHIFT_STEP;
        blank_seen = 1'b0;
        line_sum   = line_sum + ({24'd0, chr} << line_shift);
        line_shift = line_shift + SHIFT_STEP;
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        if (err_count < 30)
            $display("ERROR @%0t: %s expected 0x%0h got 0x%0h", $realtime, what, want, got);
        err_count++;
    endtask

    task automatic send_char(input logic [7:0] chr, input logic eoi, input logic lit,
                             input logic [16:0] lit_hash, input logic lit_end);
        int          gap;
        logic [16:0] h;
        logic        e;
        t_hash_rec   rec;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= chr;
        s_axis_tlast  <= eoi;
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1) @(posedge i_clk);
        if (hash_step(chr, eoi, h, e)) begin
            rec.hash   = lit ? lit_hash : h;
            rec.is_end = lit ? lit_end : e;
            line_hash_q.push_back(rec);
        end
    endtask

    // Register write only once the block has drained.
    task automatic set_blank_mode(input logic mode);
        s_axis_tvalid <= 1'b0;
        while (line_hash_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        blank_mode  = mode;
    endtask

    initial begin : result_sink
        int        stall;
        t_hash_rec want;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = $urandom_range(0, gap_max);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (m_axis_tvalid !== 1'b1) @(posedge i_clk);
            if (line_hash_q.size() == 0) begin
                report_mismatch("unexpected result beat, tdata", 0, m_axis_tdata);
            end else begin
                want = line_hash_q.pop_front();
                if (m_axis_tdata[16:0] !== want.hash)
                    report_mismatch("hash_value", want.hash, m_axis_tdata[16:0]);
                if (m_axis_tlast !== want.is_end)
                    report_mismatch("is_end", want.is_end, m_axis_tlast);
            end
        end
    end

    initial begin : byte_source
        int          r;
        logic [7:0]  chr;
        logic        eoi;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_MODE)
                set_blank_mode(directed_rows[i].mode);
            else
                send_char(directed_rows[i].chr, directed_rows[i].eoi, directed_rows[i].lit,
                          directed_rows[i].lit_hash, directed_rows[i].lit_end);
        end

        // long line of all-ones bytes so the upper half of the sum fills up
        repeat (200) send_char(8'hFF, 1'b0, 1'b0, '0, 1'b0);
        send_char(CHAR_NEWLINE, 1'b0, 1'b0, '0, 1'b0);

        for (int p = 0; p < 7; p++) begin
            set_blank_mode(~p[0]);
            gap_max = (p == 3) ? 0 : 6;
            for (int n = 0; n < 160; n++) begin
                r   = $urandom_range(0, 99);
                eoi = (r < 3);
                chr = $urandom_range(0, 255);
                if (r >= 3 && r < 11)
                    chr = CHAR_NEWLINE;
                else if (r >= 11 && r < 36)
                    chr = $urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB;
                else if (r >= 36 && r < 42)
                    chr = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                send_char(chr, eoi, 1'b0, '0, 1'b0);
            end
        end
        gap_max = 6;

        s_axis_tvalid <= 1'b0;
        while (line_hash_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
